// ----- rtl/mr256_pkg.sv -----
// shared types and constants for the montgomery reduction block
package mr256_pkg;

  localparam int WordBits   = 64;
  localparam int FieldWords = 4;
  localparam int DigitBits  = 32;
  localparam int CfgIdxBits = 3;
  localparam int AccBits    = 72;

  typedef logic [WordBits-1:0]   word_t;
  typedef logic [DigitBits-1:0]  digit_t;
  typedef logic [CfgIdxBits-1:0] cfg_idx_t;

  // first index of the inverse registers
  localparam cfg_idx_t CfgInvBase = cfg_idx_t'(FieldWords);

  // reset modulus: the p-256 prime, and its inverse modulo 2^256
  localparam word_t ModRst0 = 64'hFFFFFFFFFFFFFFFF;
  localparam word_t ModRst1 = 64'h00000000FFFFFFFF;
  localparam word_t ModRst2 = 64'h0000000000000000;
  localparam word_t ModRst3 = 64'hFFFFFFFF00000001;
  localparam word_t InvRst0 = 64'hFFFFFFFFFFFFFFFF;
  localparam word_t InvRst1 = 64'hFFFFFFFEFFFFFFFF;
  localparam word_t InvRst2 = 64'hFFFFFFFFFFFFFFFF;
  localparam word_t InvRst3 = 64'h00000000FFFFFFFD;

endpackage

// ----- rtl/montgomery_reduction_256.sv -----
// montgomery reduction of a 512-bit value modulo a 256-bit prime, r = 2^256
// steps: collect the 8 words of a, scan the digit products of m = a*ip mod r and then of t = m*p, let the last
// product drain, take the top digit of m*p, subtract word by word, add back p on a borrow, emit 4 result words
// a single shared 32x32 multiplier forms every product; no new a is taken until the last result word is loaded
// reset: async active low; clears control, loads the p-256 prime and its inverse
// the input side is ready only while collecting words; the output register holds a word
module montgomery_reduction_256 (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // configuration write port
  input  logic                        cfg_we_i,
  input  mr256_pkg::cfg_idx_t         cfg_index_i,
  input  mr256_pkg::word_t            cfg_data_i,
  // input stream
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  mr256_pkg::word_t            s_axis_tdata,   // [63:0] value_word
  // output stream
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output mr256_pkg::word_t            m_axis_tdata,   // [63:0] result_word
  output logic                        m_axis_tlast    // final_word
);

  // sequencer codes
  localparam logic [2:0] S_COLL = 3'd0;  // collecting input words
  localparam logic [2:0] S_MUL  = 3'd1;  // issuing digit products
  localparam logic [2:0] S_FIN  = 3'd2;  // last product drains into accumulator
  localparam logic [2:0] S_TOP  = 3'd3;  // top digit of m*p from leftover carry
  localparam logic [2:0] S_SUB  = 3'd4;  // high half of a minus high half of m*p
  localparam logic [2:0] S_OUT  = 3'd5;  // conditional add-back of p and emit

  localparam int NumDig = 2 * mr256_pkg::FieldWords;  // 32-bit digits in 256 bits

  logic [2:0] state_q, state_d;

  // configuration registers
  mr256_pkg::word_t mod_q [mr256_pkg::FieldWords];
  mr256_pkg::word_t inv_q [mr256_pkg::FieldWords];

  // operand store, low words first; no reset, every entry is written before use
  mr256_pkg::word_t store_q [2*mr256_pkg::FieldWords];
  logic [2:0]       cnt_q;

  // m digits and high digits of m*p (later reused for the difference)
  mr256_pkg::digit_t m_q  [NumDig];
  mr256_pkg::digit_t th_q [NumDig];

  // product-scan counters: phase (0: m = a*ip mod r, 1: t = m*p), column, row
  logic       ph_q;
  logic [3:0] k_q;
  logic [2:0] i_q;
  logic [1:0] w_q;      // word counter for subtract and output
  logic       borrow_q;
  logic       carry_q;

  // multiplier pipeline
  logic [63:0]                        prod_q;
  logic                               pv_q, plast_q, pfirst_q, pph_q;
  logic [3:0]                         pk_q;
  logic [mr256_pkg::AccBits-1:0]      acc_q;

  // output register
  logic             ov_q;
  mr256_pkg::word_t od_q;
  logic             ol_q;

  // ---------------------------------------------------------------------------
  // column bounds for the product scan
  logic [2:0] lo_nxt, hi_cur, j_cur;
  logic [3:0] k_nxt, k_end;
  logic       last_in_col, first_iss;

  always_comb begin
    k_nxt       = k_q + 4'd1;
    k_end       = ph_q ? 4'd14 : 4'd7;
    lo_nxt      = (ph_q && k_nxt[3]) ? (k_nxt[2:0] + 3'd1) : 3'd0;
    hi_cur      = (ph_q && k_q[3]) ? 3'd7 : k_q[2:0];
    j_cur       = k_q[2:0] - i_q;
    last_in_col = (i_q == hi_cur);
    first_iss   = (k_q == 4'd0) && (i_q == 3'd0);
  end

  // single read port of the operand store
  logic [2:0]       st_addr;
  mr256_pkg::word_t st_word;
  assign st_addr = (state_q == S_SUB) ? {1'b1, w_q} : {1'b0, i_q[2:1]};
  assign st_word = store_q[st_addr];

  // single read port of the modulus / inverse registers
  logic [1:0]       cf_addr;
  mr256_pkg::word_t mod_word, inv_word;
  assign cf_addr  = (state_q == S_OUT) ? w_q : j_cur[2:1];
  assign mod_word = mod_q[cf_addr];
  assign inv_word = inv_q[cf_addr];

  // multiplier operands
  mr256_pkg::digit_t x_dig, y_dig;
  always_comb begin
    if (ph_q) begin
      x_dig = m_q[i_q];
      y_dig = j_cur[0] ? mod_word[63:32] : mod_word[31:0];
    end else begin
      x_dig = i_q[0] ? st_word[63:32] : st_word[31:0];
      y_dig = j_cur[0] ? inv_word[63:32] : inv_word[31:0];
    end
  end

  // accumulator add
  logic [mr256_pkg::AccBits-1:0] acc_sum;
  assign acc_sum = (pfirst_q ? '0 : acc_q) + {8'd0, prod_q};

  // subtract and add-back datapaths, one 64-bit word per cycle; add-back stalls on a held output
  mr256_pkg::word_t t_word, addend;
  logic [64:0]      diff, osum;
  always_comb begin
    t_word = {th_q[{w_q, 1'b1}], th_q[{w_q, 1'b0}]};
    diff   = {1'b0, st_word} - {1'b0, t_word} - {64'd0, borrow_q};
    addend = mod_word & {64{borrow_q}};
    osum   = {1'b0, t_word} + {1'b0, addend} + {64'd0, carry_q};
  end

  logic in_acc, out_load;
  assign s_axis_tready = (state_q == S_COLL);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_load      = (state_q == S_OUT) && (!ov_q || m_axis_tready);

  // ---------------------------------------------------------------------------
  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_COLL: if (in_acc && cnt_q == 3'd7) state_d = S_MUL;
      S_MUL:  if (last_in_col && k_q == k_end && ph_q) state_d = S_FIN;
      S_FIN:  state_d = S_TOP;
      S_TOP:  state_d = S_SUB;
      S_SUB:  if (w_q == 2'd3) state_d = S_OUT;
      S_OUT:  if (out_load && w_q == 2'd3) state_d = S_COLL;
      default: state_d = S_COLL;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_COLL;
      cnt_q    <= '0;
      ph_q     <= 1'b0;
      k_q      <= '0;
      i_q      <= '0;
      w_q      <= '0;
      borrow_q <= 1'b0;
      carry_q  <= 1'b0;
      pv_q     <= 1'b0;
      ov_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      pv_q    <= (state_q == S_MUL);

      if (in_acc) begin
        cnt_q <= cnt_q + 3'd1;
        if (cnt_q == 3'd7) begin
          ph_q <= 1'b0;
          k_q  <= '0;
          i_q  <= '0;
        end
      end

      // step through the products of each column
      if (state_q == S_MUL) begin
        if (!last_in_col) begin
          i_q <= i_q + 3'd1;
        end else if (k_q != k_end) begin
          k_q <= k_nxt;
          i_q <= lo_nxt;
        end else if (!ph_q) begin
          ph_q <= 1'b1;
          k_q  <= '0;
          i_q  <= '0;
        end
      end

      if (state_q == S_TOP) begin
        borrow_q <= 1'b0;
        w_q      <= '0;
      end

      if (state_q == S_SUB) begin
        borrow_q <= diff[64];
        w_q      <= w_q + 2'd1;
        if (w_q == 2'd3) carry_q <= 1'b0;
      end

      if (out_load) begin
        carry_q <= osum[64];
        w_q     <= w_q + 2'd1;
        ov_q    <= 1'b1;
      end else if (m_axis_tready) begin
        ov_q <= 1'b0;
      end
    end
  end

  // configuration registers, reset to the p-256 parameters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_q[0] <= mr256_pkg::ModRst0;
      mod_q[1] <= mr256_pkg::ModRst1;
      mod_q[2] <= mr256_pkg::ModRst2;
      mod_q[3] <= mr256_pkg::ModRst3;
      inv_q[0] <= mr256_pkg::InvRst0;
      inv_q[1] <= mr256_pkg::InvRst1;
      inv_q[2] <= mr256_pkg::InvRst2;
      inv_q[3] <= mr256_pkg::InvRst3;
    end else if (cfg_we_i) begin
      if (cfg_index_i < mr256_pkg::CfgInvBase) begin
        mod_q[cfg_index_i[1:0]] <= cfg_data_i;
      end else begin
        inv_q[cfg_index_i[1:0]] <= cfg_data_i;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) store_q[cnt_q] <= s_axis_tdata;

    // multiplier stage
    prod_q   <= x_dig * y_dig;
    plast_q  <= last_in_col;
    pfirst_q <= first_iss;
    pph_q    <= ph_q;
    pk_q     <= k_q;

    // accumulate stage: retire a digit at the end of each column
    if (pv_q) begin
      if (plast_q) begin
        acc_q <= {32'd0, acc_sum[mr256_pkg::AccBits-1:32]};
        if (!pph_q) begin
          m_q[pk_q[2:0]] <= acc_sum[31:0];
        end else if (pk_q[3]) begin
          th_q[pk_q[2:0]] <= acc_sum[31:0];
        end
      end else begin
        acc_q <= acc_sum;
      end
    end

    // carry left after the last column is the top digit of m*p
    if (state_q == S_TOP) th_q[NumDig-1] <= acc_q[31:0];

    if (state_q == S_SUB) begin
      th_q[{w_q, 1'b0}] <= diff[31:0];
      th_q[{w_q, 1'b1}] <= diff[63:32];
    end

    if (out_load) begin
      od_q <= osum[63:0];
      ol_q <= (w_q == 2'd3);
    end
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = od_q;
  assign m_axis_tlast  = ol_q;

endmodule

// ----- bench/tb.sv -----
// self-checking bench for the montgomery reduction block, driven over its stream ports
module tb;

  localparam int IdlePct       = 19;    // percent of cycles either side holds back
  localparam int DrainCycles   = 120;   // wait after the owed results drain, before register writes and at the end
  localparam int WatchdogLimit = 5000;  // cycles with no handshake or register write before giving up
  localparam int FieldWords    = mr256_pkg::FieldWords;
  localparam int WordBits      = mr256_pkg::WordBits;
  localparam int StoreWords    = 2 * FieldWords;

  typedef logic [FieldWords*WordBits-1:0] field_t;
  typedef logic [StoreWords*WordBits-1:0] wide_t;

  // one result word as the output stream should carry it
  typedef struct {
    mr256_pkg::word_t word;
    logic             last;
  } result_t;

  // directed set: operand, and the reduced value where it is obvious
  typedef struct packed {
    wide_t  value;
    logic   known;
    field_t reduced;
  } vector_t;

  localparam field_t P256Mod = {mr256_pkg::ModRst3, mr256_pkg::ModRst2,
                                mr256_pkg::ModRst1, mr256_pkg::ModRst0};
  localparam field_t P256Inv = {mr256_pkg::InvRst3, mr256_pkg::InvRst2,
                                mr256_pkg::InvRst1, mr256_pkg::InvRst0};

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                cfg_we_i      = 1'b0;
  mr256_pkg::cfg_idx_t cfg_index_i   = '0;
  mr256_pkg::word_t    cfg_data_i    = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  mr256_pkg::word_t    s_axis_tdata  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  mr256_pkg::word_t    m_axis_tdata;
  logic                m_axis_tlast;

  montgomery_reduction_256 DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // [63:0] value_word
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // [63:0] result_word
    .m_axis_tlast  (m_axis_tlast)    // final_word
  );

  // shadow of the block: modulus, inverse and the words of the operand so far
  field_t           modulus    = P256Mod;
  field_t           inverse    = P256Inv;
  mr256_pkg::word_t operand_q [StoreWords];
  int               words_seen = 0;

  // reduced words still owed by the block, oldest first
  result_t reduced_words_q [$];
  result_t head;

  // a directed set may carry its own answer instead of the computed one
  logic    typed_known  = 1'b0;
  field_t  typed_result = '0;

  bit      quiet_run    = 1'b0;  // no idling on either side while set
  int      failures     = 0;
  int      stall_count  = 0;

  vector_t directed_sets [3];

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // c = a * R^-1 mod p as the block forms it: only the high half is subtracted,
  // one conditional add of p, all of it modulo 2^256
  function automatic field_t mont_reduce(wide_t a);
    wide_t          prod;
    field_t         m;
    wide_t          mp;
    logic [256:0]   diff;
    prod = {256'b0, a[255:0]} * {256'b0, inverse};
    m    = prod[255:0];
    mp   = {256'b0, m} * {256'b0, modulus};
    diff = {1'b0, a[511:256]} - {1'b0, mp[511:256]};
    if (diff[256]) begin
      return diff[255:0] + modulus;
    end
    return diff[255:0];
  endfunction

  // inverse modulo 2^256 of an odd value, by newton steps
  function automatic field_t inv_mod_r(field_t p);
    field_t x;
    x = p;  // right to three bits for any odd p
    repeat (8) x = x * (field_t'(2) - p * x);
    return x;
  endfunction

  // word values with the extremes showing up often
  function automatic mr256_pkg::word_t rand_word();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic field_t rand_field();
    field_t f;
    for (int i = 0; i < FieldWords; i++) f[WordBits*i +: WordBits] = rand_word();
    return f;
  endfunction

  // in range keeps the high half below a nonzero p, so a < R * p
  function automatic wide_t gen_operand(bit in_range);
    wide_t a;
    a = {rand_field(), rand_field()};
    if (in_range) begin
      a[511:256] = a[511:256] & (modulus >> 1);
    end
    return a;
  endfunction

  // accepted word goes into the shadow store; the eighth one yields four results
  task automatic collect_word(mr256_pkg::word_t w);
    wide_t  a;
    field_t c;
    operand_q[words_seen] = w;
    words_seen++;
    if (words_seen == StoreWords) begin
      words_seen = 0;
      for (int i = 0; i < StoreWords; i++) a[WordBits*i +: WordBits] = operand_q[i];
      c = typed_known ? typed_result : mont_reduce(a);
      for (int i = 0; i < FieldWords; i++) begin
        reduced_words_q.push_back('{word: c[WordBits*i +: WordBits], last: i == FieldWords-1});
      end
    end
  endtask

  // one request on the input side, with a random gap in front
  task automatic send_word(mr256_pkg::word_t w);
    while (!quiet_run && $urandom_range(99) < IdlePct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= w;
    do @(posedge clk_i); while (!s_axis_tready);
    collect_word(w);
  endtask

  task automatic send_set(wide_t a, logic known, field_t reduced);
    typed_known  = known;
    typed_result = reduced;
    for (int i = 0; i < StoreWords; i++) send_word(a[WordBits*i +: WordBits]);
    typed_known  = 1'b0;
  endtask

  // registers only change with the block idle: results drained, then the DrainCycles wait
  task automatic write_config(field_t mod, field_t inv);
    s_axis_tvalid <= 1'b0;
    while (reduced_words_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    for (int i = 0; i < FieldWords; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_index_i <= mr256_pkg::cfg_idx_t'(i);
      cfg_data_i  <= mod[WordBits*i +: WordBits];
      @(posedge clk_i);
      modulus[WordBits*i +: WordBits] = mod[WordBits*i +: WordBits];
    end
    for (int i = 0; i < FieldWords; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_index_i <= mr256_pkg::CfgInvBase + mr256_pkg::cfg_idx_t'(i);
      cfg_data_i  <= inv[WordBits*i +: WordBits];
      @(posedge clk_i);
      inverse[WordBits*i +: WordBits] = inv[WordBits*i +: WordBits];
    end
    cfg_we_i <= 1'b0;
  endtask

  // write the registers, then alternate in-range operands with arbitrary ones
  task automatic run_phase(field_t mod, field_t inv, int sets, bit quiet);
    field_t none;
    none = '0;
    write_config(mod, inv);
    quiet_run = quiet;
    for (int k = 0; k < sets; k++) send_set(gen_operand(k % 2 == 0), 1'b0, none);
    quiet_run = 1'b0;
  endtask

  // output side: check every accepted word against the oldest owed one
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (reduced_words_q.size() == 0) begin
        $error("result_word: none expected, got %h", m_axis_tdata);
        failures++;
      end else begin
        head = reduced_words_q.pop_front();
        if (m_axis_tdata !== head.word) begin
          $error("result_word: expected %h, got %h", head.word, m_axis_tdata);
          failures++;
        end
        if (m_axis_tlast !== head.last) begin
          $error("final_word: expected %b, got %b", head.last, m_axis_tlast);
          failures++;
        end
      end
    end
    m_axis_tready <= quiet_run || ($urandom_range(99) >= IdlePct);
  end

  // watchdog: any handshake or register write counts as progress
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i) begin
      stall_count = 0;
    end else begin
      stall_count++;
    end
    if (stall_count >= WatchdogLimit) begin
      $display("montgomery_reduction_256: mismatch");
      $finish;
    end
  end

  initial begin
    field_t p;
    // zero in, zero out
    directed_sets[0] = '{value: '0, known: 1'b1, reduced: '0};
    // low half zero means m = 0, so the high half comes straight back,
    // even far above R * p where nothing is flagged
    directed_sets[1] = '{value: {{256{1'b1}}, 256'b0}, known: 1'b1, reduced: '1};
    // every bit set: low half drives m, predictor decides
    directed_sets[2] = '{value: '1, known: 1'b0, reduced: '0};

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset modulus and inverse
    for (int i = 0; i < 3; i++) begin
      send_set(directed_sets[i].value, directed_sets[i].known, directed_sets[i].reduced);
    end
    for (int k = 0; k < 2; k++) send_set(gen_operand(k % 2 == 0), 1'b0, '0);

    // random odd modulus with its true inverse, both sides never idle
    p = rand_field() | field_t'(1) | (field_t'(1) << 255);
    run_phase(p, inv_mod_r(p), 4, 1'b1);
    // largest modulus, its own inverse
    run_phase('1, inv_mod_r('1), 2, 1'b0);
    // smallest odd modulus
    run_phase(field_t'(1), field_t'(1), 2, 1'b0);
    // arbitrary modulus and an inverse that does not match it
    run_phase(rand_field(), rand_field(), 2, 1'b0);
    // zero modulus: the product vanishes and no borrow can occur
    run_phase('0, rand_field(), 2, 1'b0);
    // back to the reset values
    run_phase(P256Mod, P256Inv, 2, 1'b0);

    s_axis_tvalid <= 1'b0;
    while (reduced_words_q.size() != 0) @(posedge clk_i);
    // catch any stray words after the last owed one
    repeat (DrainCycles) @(posedge clk_i);
    if (failures == 0) begin
      $display("montgomery_reduction_256: match");
    end else begin
      $display("montgomery_reduction_256: mismatch");
    end
    $finish;
  end

endmodule
